// ----- hw/rtl/sme_pkg.sv -----
// shared types and constants of the stack machine executor
package sme_pkg;

  typedef enum logic [4:0] {
    OP_HALT   = 5'd0,  OP_PUSH   = 5'd1,  OP_POP    = 5'd2,  OP_LSHIFT = 5'd3,
    OP_RSHIFT = 5'd4,  OP_ADD    = 5'd5,  OP_SUB    = 5'd6,  OP_MUL    = 5'd7,
    OP_DIV    = 5'd8,  OP_MOD    = 5'd9,  OP_BAND   = 5'd10, OP_BOR    = 5'd11,
    OP_BXOR   = 5'd12, OP_EQ     = 5'd13, OP_NEQ    = 5'd14, OP_LT     = 5'd15,
    OP_GT     = 5'd16, OP_LTE    = 5'd17, OP_GTE    = 5'd18, OP_LAND   = 5'd19,
    OP_LOR    = 5'd20, OP_GSTORE = 5'd21, OP_GLOAD  = 5'd22, OP_BR     = 5'd23,
    OP_BRT    = 5'd24, OP_BRF    = 5'd25, OP_LOAD   = 5'd26, OP_STORE  = 5'd27,
    OP_CALL   = 5'd28, OP_RET    = 5'd29, OP_PRINTI = 5'd30, OP_PRINTC = 5'd31
  } opcode_t;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0, FLT_CHAR = 2'd1, FLT_DIV0 = 2'd2, FLT_STACK = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0, PK_INT = 2'd1, PK_CHAR = 2'd2
  } print_kind_t;

  // stack memory read select
  typedef enum logic [2:0] {
    RA_TOP, RA_TOP1, RA_FRAME_IDX, RA_FP, RA_FP1, RA_FP2
  } raddr_sel_t;

  // stack memory write select
  typedef enum logic [2:0] {
    WA_TOP1, WA_TOP, WA_TOPM1, WA_FRAME_IDX, WA_TOP2, WA_TOP3, WA_RET
  } waddr_sel_t;

  typedef enum logic [2:0] {
    WD_W1, WD_GLOBAL, WD_ALU, WD_RD, WD_W2, WD_FP, WD_SAVED, WD_A
  } wdata_sel_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5,
    ST_DIV, ST_EXEC, ST_CALL2, ST_CALL3, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_item;
    logic       rd_en;
    raddr_sel_t rsel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_c;
    logic       cap_d;
    logic       wr_en;
    waddr_sel_t wsel;
    wdata_sel_t dsel;
    logic       g_wr;
    logic       g_rd;
    logic       div_start;
    logic       commit;
    logic       clr_step;
  } sme_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    empty;
    logic    lt2;
    logic    full1;
    logic    full3;
    logic    fidx_bad;
    logic    fp_lt2;
    logic    div_done;
    logic    clr_done;
  } sme_stat_t;

  localparam logic signed [31:0] CHAR_LIMIT = 32'sd127;

endpackage

// ----- hw/rtl/sme_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hw/rtl/sme_div.sv -----
// iterative signed divider, one quotient bit a cycle
module sme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot,
  output logic [31:0] rem
);
  logic [31:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, nq_r, nq_nxt, nr_r, nr_nxt;
  logic [32:0] trial;
  logic [31:0] rsh;

  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; nq_nxt = nq_r; nr_nxt = nr_r;
    rsh = {r_r[30:0], q_r[31]};
    trial = {1'b0, rsh} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend[31] ? (32'd0 - dividend) : dividend;
      d_nxt = divisor[31] ? (32'd0 - divisor) : divisor;
      r_nxt = '0;
      cnt_nxt = 6'd0;
      busy_nxt = 1'b1;
      nq_nxt = dividend[31] ^ divisor[31];
      nr_nxt = dividend[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = rsh;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; nq_r <= nq_nxt; nr_r <= nr_nxt;
  end

  assign done = !busy_r && (cnt_r == 6'd32);
  assign quot = nq_r ? (32'd0 - q_r) : q_r;
  assign rem  = nr_r ? (32'd0 - r_r) : r_r;
endmodule

// ----- hw/rtl/sme_ctrl.sv -----
// controller state machine of the stack machine executor
module sme_ctrl
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  sme_stat_t st,
  output sme_cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   fault_stack;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // a new beat is taken only once the result register is free or emptying
  assign in_tready  = (state_r == ST_IDLE) && (!ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.rsel   = RA_TOP;
    cmd.wsel   = WA_TOP1;
    cmd.dsel   = WD_W1;
    fault_stack = 1'b0;
    if (out_tvalid && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load_item = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // range checks that need no memory data
        unique case (st.op)
          OP_PUSH, OP_GLOAD: fault_stack = st.full1;
          OP_POP, OP_GSTORE, OP_BRT, OP_BRF, OP_PRINTI, OP_PRINTC:
            fault_stack = st.empty;
          OP_LOAD:  fault_stack = st.fidx_bad || st.full1;
          OP_STORE: fault_stack = st.fidx_bad || st.empty;
          OP_CALL:  fault_stack = st.full3;
          OP_RET:   fault_stack = st.empty || st.fp_lt2;
          OP_HALT, OP_BR: fault_stack = 1'b0;
          default:  fault_stack = st.lt2;
        endcase
        cmd.rd_en = 1'b1;
        cmd.g_rd  = 1'b1;
        unique case (st.op)
          OP_LOAD: cmd.rsel = RA_FRAME_IDX;
          default: cmd.rsel = RA_TOP;
        endcase
        if (fault_stack || st.op == OP_HALT || st.op == OP_BR || st.op == OP_POP ||
            st.op == OP_PUSH || st.op == OP_GLOAD || st.op == OP_CALL) begin
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        // data of first read lands as a
        cmd.cap_a = 1'b1;
        if (st.op == OP_RET) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_FP;
          state_nxt = ST_RD2;
        end else if (st.op == OP_LOAD || st.op == OP_STORE || st.op == OP_GSTORE ||
                     st.op == OP_BRT || st.op == OP_BRF ||
                     st.op == OP_PRINTI || st.op == OP_PRINTC) begin
          state_nxt = ST_EXEC;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_TOP1;
          state_nxt = ST_RD2;
        end
      end
      ST_RD2: begin
        cmd.cap_b = 1'b1;
        if (st.op == OP_RET) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RA_FP1;
          state_nxt = ST_RD3;
        end else if (st.op == OP_DIV || st.op == OP_MOD) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EXEC;
        end
      end
      ST_RD3: begin
        cmd.cap_c = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rsel  = RA_FP2;
        state_nxt = ST_RD4;
      end
      ST_RD4: begin
        cmd.cap_d = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_DIV: begin
        if (st.div_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // datapath decides write and fault, controller sequences calls
        cmd.commit = 1'b1;
        cmd.wr_en  = 1'b1;
        cmd.g_wr   = 1'b1;
        unique case (st.op)
          OP_PUSH:  begin cmd.wsel = WA_TOP1;      cmd.dsel = WD_W1;     end
          OP_GLOAD: begin cmd.wsel = WA_TOP1;      cmd.dsel = WD_GLOBAL; end
          OP_LOAD:  begin cmd.wsel = WA_TOP1;      cmd.dsel = WD_A;      end
          OP_STORE: begin cmd.wsel = WA_FRAME_IDX; cmd.dsel = WD_A;      end
          OP_CALL:  begin cmd.wsel = WA_TOP1;      cmd.dsel = WD_W2;     end
          OP_RET:   begin cmd.wsel = WA_RET;       cmd.dsel = WD_A;      end
          default:  begin cmd.wsel = WA_TOPM1;     cmd.dsel = WD_ALU;    end
        endcase
        state_nxt = ST_OUT;
        if (st.op == OP_CALL && !st.full3) begin
          cmd.commit = 1'b0;
          state_nxt  = ST_CALL2;
        end
      end
      ST_CALL2: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WA_TOP2;
        cmd.dsel  = WD_FP;
        state_nxt = ST_CALL3;
      end
      ST_CALL3: begin
        cmd.wr_en  = 1'b1;
        cmd.wsel   = WA_TOP3;
        cmd.dsel   = WD_SAVED;
        cmd.commit = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/sme_dpath.sv -----
// datapath: pointers, stack and global memories, alu, result register
module sme_dpath
  import sme_pkg::*;
#(
  parameter int STACK_WORDS  = 256,
  parameter int GLOBAL_WORDS = 256,
  parameter int ADDRESS_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sme_cmd_t                cmd,
  output sme_stat_t               st,
  input  logic [4:0]              item_mode,
  input  logic [31:0]             item_w1,
  input  logic [31:0]             item_w2,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  output logic [ADDRESS_BITS-1:0] res_next_address,
  output logic [1:0]              res_print_kind,
  output logic [31:0]             res_print_value,
  output logic                    res_halted,
  output logic [1:0]              res_fault_code
);
  localparam int SAW = $clog2(STACK_WORDS);
  localparam int GAW = (GLOBAL_WORDS > 1) ? $clog2(GLOBAL_WORDS) : 1;
  localparam int PW  = SAW + 1;
  localparam logic signed [PW:0] SMAX = (PW + 1)'(STACK_WORDS - 1);

  opcode_t op_r;
  logic [31:0] w1_r, w2_r;
  logic [15:0] entry_r;
  logic [ADDRESS_BITS-1:0] ia_r, ia_nxt;
  logic signed [PW-1:0] sp_r, sp_nxt, fp_r, fp_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [SAW:0] clr_r;
  logic [31:0] rdata, gdata, wdata;
  logic [SAW-1:0] raddr, waddr, clr_idx;
  logic we;
  logic g_in_range;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r <= opcode_t'(item_mode);
      w1_r <= item_w1;
      w2_r <= item_w2;
    end
    if (cmd.cap_a) a_r <= rdata;
    if (cmd.cap_b) b_r <= rdata;
    if (cmd.cap_c) c_r <= rdata;
    if (cmd.cap_d) d_r <= rdata;
  end

  // frame index, sign extended wide compare
  logic signed [33:0] fidx;
  assign fidx = 34'(fp_r) + 34'(signed'(w1_r));
  logic signed [PW:0] sp_w;
  assign sp_w = (PW + 1)'(sp_r);

  assign st.op       = op_r;
  assign st.empty    = sp_r < 0;
  assign st.lt2      = sp_r < 1;
  assign st.full1    = sp_w + 1 > SMAX;
  assign st.full3    = sp_w + 3 > SMAX;
  assign st.fidx_bad = fidx < 0 || fidx > 34'(STACK_WORDS - 1);
  assign st.fp_lt2   = fp_r < 2;
  assign st.clr_done = clr_r[SAW];

  // divider, dividend taken straight from the read port as b lands
  logic        div_done;
  logic [31:0] quot, rem;
  sme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(rdata), .divisor(a_r),
    .done(div_done), .quot(quot), .rem(rem)
  );
  assign st.div_done = div_done;

  // alu
  logic [31:0] alu;
  logic signed [31:0] sa, sb;
  assign sa = signed'(a_r);
  assign sb = signed'(b_r);
  always_comb begin
    unique case (op_r)
      OP_LSHIFT: alu = b_r << a_r[4:0];
      OP_RSHIFT: alu = unsigned'(sb >>> a_r[4:0]);
      OP_ADD:    alu = a_r + b_r;
      OP_SUB:    alu = b_r - a_r;
      OP_MUL:    alu = a_r * b_r;
      OP_DIV:    alu = quot;
      OP_MOD:    alu = rem;
      OP_BAND:   alu = b_r & a_r;
      OP_BOR:    alu = b_r | a_r;
      OP_BXOR:   alu = b_r ^ a_r;
      OP_EQ:     alu = {31'd0, a_r == b_r};
      OP_NEQ:    alu = {31'd0, a_r != b_r};
      OP_LT:     alu = {31'd0, sb < sa};
      OP_GT:     alu = {31'd0, sb > sa};
      OP_LTE:    alu = {31'd0, sb <= sa};
      OP_GTE:    alu = {31'd0, sb >= sa};
      OP_LAND:   alu = {31'd0, (b_r != 0) && (a_r != 0)};
      OP_LOR:    alu = {31'd0, (b_r != 0) || (a_r != 0)};
      default:   alu = '0;
    endcase
  end

  // ret checks
  logic signed [33:0] nfp, nsp;
  assign nfp = 34'(signed'(c_r));
  assign nsp = 34'(fp_r) - 34'sd3 - 34'(signed'(d_r));
  logic ret_bad;
  assign ret_bad = nfp < -1 || nfp > 34'(STACK_WORDS - 1) ||
                   nsp < -1 || nsp > 34'(STACK_WORDS - 2);

  // fault evaluation at commit
  fault_t fault;
  logic   stack_bad;
  always_comb begin
    unique case (op_r)
      OP_PUSH, OP_GLOAD: stack_bad = st.full1;
      OP_POP, OP_GSTORE, OP_BRT, OP_BRF, OP_PRINTI, OP_PRINTC: stack_bad = st.empty;
      OP_LOAD:  stack_bad = st.fidx_bad || st.full1;
      OP_STORE: stack_bad = st.fidx_bad || st.empty;
      OP_CALL:  stack_bad = st.full3;
      OP_RET:   stack_bad = st.empty || st.fp_lt2 || ret_bad;
      OP_HALT, OP_BR: stack_bad = 1'b0;
      default:  stack_bad = st.lt2;
    endcase
    if (stack_bad) fault = FLT_STACK;
    else if ((op_r == OP_DIV || op_r == OP_MOD) && a_r == 0) fault = FLT_DIV0;
    else if (op_r == OP_PRINTC && signed'(a_r) > CHAR_LIMIT) fault = FLT_CHAR;
    else fault = FLT_NONE;
  end

  logic halt;
  assign halt = (op_r == OP_HALT) || (fault != FLT_NONE);

  // memory addresses
  logic signed [PW-1:0] ret_sp;
  assign ret_sp = PW'(nsp + 34'sd1);
  always_comb begin
    unique case (cmd.rsel)
      RA_TOP:       raddr = SAW'(sp_r);
      RA_TOP1:      raddr = SAW'(sp_r - 1);
      RA_FRAME_IDX: raddr = SAW'(fidx);
      RA_FP:        raddr = SAW'(fp_r);
      RA_FP1:       raddr = SAW'(fp_r - 1);
      RA_FP2:       raddr = SAW'(fp_r - 2);
      default:      raddr = SAW'(sp_r);
    endcase
    unique case (cmd.wsel)
      WA_TOP1:      waddr = SAW'(sp_r + 1);
      WA_TOP:       waddr = SAW'(sp_r);
      WA_TOPM1:     waddr = SAW'(sp_r - 1);
      WA_FRAME_IDX: waddr = SAW'(fidx);
      WA_TOP2:      waddr = SAW'(sp_r + 2);
      WA_TOP3:      waddr = SAW'(sp_r + 3);
      WA_RET:       waddr = SAW'(ret_sp);
      default:      waddr = SAW'(sp_r);
    endcase
    unique case (cmd.dsel)
      WD_W1:     wdata = w1_r;
      WD_GLOBAL: wdata = g_in_range ? gdata : 32'd0;
      WD_ALU:    wdata = alu;
      WD_RD:     wdata = rdata;
      WD_W2:     wdata = w2_r;
      WD_FP:     wdata = 32'(fp_r);
      WD_SAVED:  wdata = 32'(ia_r + ADDRESS_BITS'(2));
      WD_A:      wdata = a_r;
      default:   wdata = '0;
    endcase
  end

  // stores happen only for ops that write and did not fault
  logic op_writes;
  always_comb begin
    unique case (op_r)
      OP_HALT, OP_POP, OP_GSTORE, OP_BR, OP_BRT, OP_BRF, OP_PRINTI, OP_PRINTC:
        op_writes = 1'b0;
      default: op_writes = 1'b1;
    endcase
  end
  assign clr_idx = clr_r[SAW-1:0];
  assign we = cmd.clr_step || (cmd.wr_en && op_writes && fault == FLT_NONE);

  sme_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
    .clk(clk), .we(we), .waddr(cmd.clr_step ? clr_idx : waddr),
    .wdata(cmd.clr_step ? 32'd0 : wdata),
    .re(cmd.rd_en), .raddr(raddr), .rdata(rdata)
  );

  assign g_in_range = !w1_r[31] && (w1_r < 32'(GLOBAL_WORDS));
  sme_ram #(.WIDTH(32), .DEPTH(GLOBAL_WORDS)) u_glob (
    .clk(clk),
    .we(cmd.g_wr && op_r == OP_GSTORE && fault == FLT_NONE && g_in_range),
    .waddr(GAW'(w1_r)), .wdata(a_r),
    .re(cmd.g_rd), .raddr(GAW'(w1_r)), .rdata(gdata)
  );

  // next address and pointer update
  logic [ADDRESS_BITS-1:0] ia1, ia2, tgt;
  logic [1:0]  kind;
  always_comb begin
    ia1 = ia_r + ADDRESS_BITS'(1);
    ia2 = ia_r + ADDRESS_BITS'(2);
    tgt = ADDRESS_BITS'(w1_r);
    sp_nxt = sp_r;
    fp_nxt = fp_r;
    ia_nxt = ia1;
    kind = PK_NONE;
    unique case (op_r)
      OP_PUSH, OP_GLOAD, OP_LOAD: begin sp_nxt = PW'(sp_r + 1); ia_nxt = ia2; end
      OP_POP, OP_PRINTI, OP_PRINTC: sp_nxt = PW'(sp_r - 1);
      OP_GSTORE, OP_STORE: begin sp_nxt = PW'(sp_r - 1); ia_nxt = ia2; end
      OP_BR: ia_nxt = tgt;
      OP_BRT: begin
        sp_nxt = PW'(sp_r - 1);
        ia_nxt = (a_r == 32'd1) ? tgt : ia2;
      end
      OP_BRF: begin
        sp_nxt = PW'(sp_r - 1);
        ia_nxt = (a_r == 32'd0) ? tgt : ia2;
      end
      OP_CALL: begin sp_nxt = PW'(sp_r + 3); fp_nxt = PW'(sp_r + 3); ia_nxt = tgt; end
      OP_RET: begin
        fp_nxt = PW'(nfp);
        sp_nxt = ret_sp;
        ia_nxt = ADDRESS_BITS'(b_r) + ADDRESS_BITS'(1);
      end
      OP_HALT: ia_nxt = ia1;
      default: sp_nxt = PW'(sp_r - 1);
    endcase
    if (op_r == OP_PRINTI) kind = PK_INT;
    if (op_r == OP_PRINTC) kind = PK_CHAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      ia_r    <= '0;
      sp_r    <= '1;
      fp_r    <= '1;
      clr_r   <= '0;
    end else begin
      if (cmd.clr_step && !clr_r[SAW]) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) begin
        entry_r <= cfg_wr_data;
        ia_r    <= ADDRESS_BITS'(cfg_wr_data);
        sp_r    <= '1;
        fp_r    <= '1;
      end else if (cmd.commit) begin
        if (halt) begin
          ia_r <= ADDRESS_BITS'(entry_r);
          sp_r <= '1;
          fp_r <= '1;
        end else begin
          ia_r <= ia_nxt;
          sp_r <= sp_nxt;
          fp_r <= fp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_next_address <= halt ? ADDRESS_BITS'(entry_r) : ia_nxt;
      res_print_kind   <= halt ? PK_NONE : kind;
      res_print_value  <= (halt || kind == PK_NONE) ? 32'd0 : a_r;
      res_halted       <= halt;
      res_fault_code   <= fault;
    end
  end
endmodule

// ----- hw/rtl/stack_machine_execute.sv -----
// top level of the stack machine executor
//
//  channel   dir  tdata fields (lsb first)                       tuser
//  in_       in   mode[4:0], first_operand[36:5], second_op[68:37]  -
//  out_      out  next_address[15:0], print_value[47:16]   kind, halted, fault
//  cfg_      in   entry_address[15:0]                               -
//
// one item at a time: an item is taken, decoded, reads the stack words it needs (div
// and mod also wait for the divider, call writes its frame words), executes and
// registers its result before the next beat can be taken.
// after reset a clearing pass writes every stack word
// before the first beat is taken. the result waits in an output register;
// the next item is taken only when that register is free or emptying that cycle.
module stack_machine_execute
  import sme_pkg::*;
#(
  parameter int STACK_WORDS  = 256,
  parameter int GLOBAL_WORDS = 256,
  parameter int ADDRESS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // mode, first_operand, second_operand
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [ADDRESS_BITS+31:0] out_tdata, // next_address, print_value
  output logic [4:0]  out_tuser,  // print_kind, halted, fault_code
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  sme_cmd_t  cmd;
  sme_stat_t st;
  logic [ADDRESS_BITS-1:0] na;
  logic [1:0]  pk, fc;
  logic [31:0] pv;
  logic        hl;

  sme_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .st(st), .cmd(cmd)
  );

  sme_dpath #(
    .STACK_WORDS(STACK_WORDS), .GLOBAL_WORDS(GLOBAL_WORDS), .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .item_mode(in_tdata[4:0]), .item_w1(in_tdata[36:5]), .item_w2(in_tdata[68:37]),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .res_next_address(na), .res_print_kind(pk), .res_print_value(pv),
    .res_halted(hl), .res_fault_code(fc)
  );

  assign out_tdata = {pv, na};
  assign out_tuser = {fc, hl, pk};
endmodule
